/* src/sacd_pkg.sv */
// Shared constants and codes for the cache directory with LRU replacement.
`timescale 1ns / 1ps

package sacd_pkg;

    // Fixed field widths of the stream words
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 20;
    localparam int SET_NUM_W  = 7;
    localparam int WAY_NUM_W  = 3;
    localparam int KIND_W     = 3;
    localparam int BUS_W      = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Default geometry
    localparam int DEF_SETS       = 128;
    localparam int DEF_WAYS       = 8;
    localparam int DEF_LINE_BYTES = 32;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'd2097152;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_READ_MISS     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ_HIT      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_MISS    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE_HIT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WRITE_IGNORED = 3'd4;

    // Bus requests
    localparam logic [BUS_W-1:0] BUS_NONE      = 2'd0;
    localparam logic [BUS_W-1:0] BUS_LINE_READ = 2'd1;
    localparam logic [BUS_W-1:0] BUS_WRITE     = 2'd2;

endpackage

/* src/sacd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sacd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sacd_way_sel.sv */
// Per-set tag compare, victim choice and LRU age / tag / valid row update.
`timescale 1ns / 1ps

module sacd_way_sel #(
    parameter int WAYS = sacd_pkg::DEF_WAYS
) (
    input  logic [sacd_pkg::TAG_W-1:0]              tag,
    input  logic [WAYS*sacd_pkg::TAG_W-1:0]         tag_row,
    input  logic [WAYS-1:0]                         valid_row,
    input  logic [WAYS*$clog2(WAYS)-1:0]            age_row,
    output logic                                    hit,
    output logic [$clog2(WAYS)-1:0]                 way,
    output logic [WAYS*sacd_pkg::TAG_W-1:0]         tag_row_next,
    output logic [WAYS-1:0]                         valid_row_next,
    output logic [WAYS*$clog2(WAYS)-1:0]            age_row_next
);
    import sacd_pkg::*;

    localparam int WAY_W = $clog2(WAYS);
    localparam logic [WAY_W-1:0] OLDEST = WAY_W'(WAYS - 1);

    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  oldest;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] old_way;
    logic             any_free;
    logic [WAY_W-1:0] mine;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i]  = valid_row[i] && (tag_row[i*TAG_W +: TAG_W] == tag);
            oldest[i] = (age_row[i*WAY_W +: WAY_W] == OLDEST);
        end
    end

    // lowest-numbered way wins in every search
    always_comb
    begin
        hit_way  = '0;
        free_way = '0;
        old_way  = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_way = WAY_W'(i);
            end
            if (!valid_row[i])
            begin
                free_way = WAY_W'(i);
            end
            if (oldest[i])
            begin
                old_way = WAY_W'(i);
            end
        end
    end

    assign hit      = |match;
    assign any_free = ~&valid_row;

    // ages in a set always form a permutation, so exactly one way is oldest
    always_comb
    begin
        priority if (hit)
        begin
            way = hit_way;
        end
        else if (any_free)
        begin
            way = free_way;
        end
        else
        begin
            way = old_way;
        end
    end

    assign mine = age_row[way*WAY_W +: WAY_W];

    always_comb
    begin
        tag_row_next   = tag_row;
        valid_row_next = valid_row;
        age_row_next   = age_row;
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_W'(i) == way)
            begin
                age_row_next[i*WAY_W +: WAY_W] = '0;
                valid_row_next[i]              = 1'b1;
                if (!hit)
                begin
                    tag_row_next[i*TAG_W +: TAG_W] = tag;
                end
            end
            else if (age_row[i*WAY_W +: WAY_W] < mine)
            begin
                age_row_next[i*WAY_W +: WAY_W] = age_row[i*WAY_W +: WAY_W] + 1'b1;
            end
        end
    end

endmodule

/* src/set_assoc_cache_directory_lru_unit.sv */
// Top level of the set-associative cache directory with true-LRU replacement.
//
// Usage:
//   s_* channel takes one access word: cmd (read/write) and byte address.
//   m_* channel returns one result word per access: hit kind, set, way,
//   tag and the bus request needed (line read on read miss, write on
//   write miss, none on hits and on ignored writes).
//   cfg_* channel writes memory_limit; writes at or above it are ignored.
//   It is always ready and should only be written while no access is open.
// Timing:
//   An access first reads the set row from the tag and LRU RAMs, then
//   compares, picks the way and writes the row back. The next access is
//   taken in the cycle after write-back, so a new word is not accepted
//   until the last one is through the single read-modify-write of the
//   set row.
// Reset:
//   After rst_n releases, the LRU/valid RAM is swept one set per cycle,
//   through all SETS sets, with s_tready low. Tags are not cleared.
// Stall:
//   The result sits in an output register; one further access is taken
//   and read while it waits, then the block holds until m_tready.
`timescale 1ns / 1ps

module set_assoc_cache_directory_lru_unit #(
    parameter int SETS       = sacd_pkg::DEF_SETS,
    parameter int WAYS       = sacd_pkg::DEF_WAYS,
    parameter int LINE_BYTES = sacd_pkg::DEF_LINE_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // access word: [0] cmd, [32:1] address, [39:33] zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sacd_pkg::IN_DATA_W-1:0]      s_tdata,
    // result word: [2:0] hit_kind, [9:3] set_number, [12:10] way_number,
    // [32:13] tag_value, [34:33] bus_op, [39:35] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sacd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // memory_limit register
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacd_pkg::ADDR_W-1:0]         cfg_data
);
    import sacd_pkg::*;

    localparam int OFF_W    = $clog2(LINE_BYTES);
    localparam int SET_W    = $clog2(SETS);
    localparam int WAY_W    = $clog2(WAYS);
    localparam int TAG_ROW  = WAYS * TAG_W;
    localparam int AGE_ROW  = WAYS * WAY_W;
    localparam int META_W   = WAYS + AGE_ROW;
    localparam int PAD_W    = OUT_DATA_W - (KIND_W + SET_NUM_W + WAY_NUM_W + TAG_W + BUS_W);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [SET_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]  limit_reg;
    logic               cmd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic               in_cmd;
    logic [ADDR_W-1:0]  in_addr;
    logic               accept;
    logic               finish;
    logic               ignored;
    logic [SET_W-1:0]   set_idx;
    logic [TAG_W-1:0]   tag;

    logic [TAG_ROW-1:0] tag_rd;
    logic [META_W-1:0]  meta_rd;
    logic [TAG_ROW-1:0] tag_wr;
    logic [WAYS-1:0]    valid_wr;
    logic [AGE_ROW-1:0] age_wr;
    logic [AGE_ROW-1:0] age_init;
    logic               tag_we;
    logic               meta_we;
    logic [SET_W-1:0]   meta_waddr;
    logic [META_W-1:0]  meta_wdata;

    logic               hit;
    logic [WAY_W-1:0]   way;
    logic [KIND_W-1:0]  kind;
    logic [BUS_W-1:0]   bus;
    logic [WAY_NUM_W-1:0] way_num;

    assign in_cmd  = s_tdata[0];
    assign in_addr = s_tdata[ADDR_W:1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign set_idx = addr_reg[OFF_W +: SET_W];
    assign tag     = TAG_W'(addr_reg >> (OFF_W + SET_W));
    assign ignored = (cmd_reg == CMD_WRITE) && (addr_reg >= limit_reg);
    assign finish  = (state_reg == ST_LOOKUP) && (!m_tvalid_reg || m_tready);

    genvar g;
    generate
        for (g = 0; g < WAYS; g++)
        begin : g_age_init
            assign age_init[g*WAY_W +: WAY_W] = WAY_W'(g);
        end
    endgenerate

    sacd_ram #(
        .WIDTH (TAG_ROW),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (set_idx),
        .wdata (tag_wr),
        .re    (accept),
        .raddr (in_addr[OFF_W +: SET_W]),
        .rdata (tag_rd)
    );

    // meta row: {ages, valid bits}
    sacd_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (in_addr[OFF_W +: SET_W]),
        .rdata (meta_rd)
    );

    sacd_way_sel #(
        .WAYS (WAYS)
    ) u_way_sel (
        .tag            (tag),
        .tag_row        (tag_rd),
        .valid_row      (meta_rd[WAYS-1:0]),
        .age_row        (meta_rd[META_W-1:WAYS]),
        .hit            (hit),
        .way            (way),
        .tag_row_next   (tag_wr),
        .valid_row_next (valid_wr),
        .age_row_next   (age_wr)
    );

    assign tag_we     = finish && !ignored;
    assign meta_we    = (state_reg == ST_CLEAR) || (finish && !ignored);
    assign meta_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_idx;
    assign meta_wdata = (state_reg == ST_CLEAR) ? {age_init, {WAYS{1'b0}}}
                                                : {age_wr, valid_wr};

    always_comb
    begin
        priority if (ignored)
        begin
            kind = KIND_WRITE_IGNORED;
            bus  = BUS_NONE;
        end
        else if (cmd_reg == CMD_WRITE)
        begin
            kind = hit ? KIND_WRITE_HIT : KIND_WRITE_MISS;
            bus  = hit ? BUS_NONE : BUS_WRITE;
        end
        else
        begin
            kind = hit ? KIND_READ_HIT : KIND_READ_MISS;
            bus  = hit ? BUS_NONE : BUS_LINE_READ;
        end
    end

    assign way_num = ignored ? '0 : WAY_NUM_W'(way);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (finish)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_cmd;
            addr_reg <= in_addr;
        end
        if (finish)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, bus, tag, way_num,
                            SET_NUM_W'(set_idx), kind};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // an accepted word always moves on to the set lookup
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("accepted word did not enter lookup");

    // a new result only appears after a lookup
    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result appeared without lookup");

    // a hit never names a way that was not valid
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) && hit |-> meta_rd[way])
        else $error("hit on invalid way");

    // no bus transfer is requested on a hit
    a_hit_no_bus: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (m_tdata_reg[KIND_W-1:0] == KIND_READ_HIT
            || m_tdata_reg[KIND_W-1:0] == KIND_WRITE_HIT)
        |-> m_tdata_reg[KIND_W+SET_NUM_W+WAY_NUM_W+TAG_W +: BUS_W] == BUS_NONE)
        else $error("bus request on hit");

endmodule
